>>> design/wwts_pkg.sv
// Shared types, constants and character helpers for the whole-word text search core.
// No dependencies; every other design file uses it by scoped name.

package wwts_pkg;

   localparam int MAX_PATTERN_DEF = 32;
   localparam int CHAR_BITS_DEF   = 16;
   localparam int WORD_BITS       = 32;
   localparam int OPCODE_W        = 2;
   localparam int PIDX_W          = 5;
   localparam int PLEN_W          = 6;
   localparam int CSR_ADDR_W      = 4;
   localparam int CSR_DATA_W      = 32;
   localparam int FIFO_DEPTH      = 4;

   localparam logic [WORD_BITS-1:0] SAT_WORD = '1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOAD = 2'd0,
      OP_TEXT = 2'd1,
      OP_END  = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      REG_PATTERN_LENGTH = 2'd0,
      REG_CASE_SENSITIVE = 2'd1,
      REG_WHOLE_WORD     = 2'd2
   } reg_index_type;

   localparam logic KIND_MATCH = 1'b0;
   localparam logic KIND_DONE  = 1'b1;

   typedef struct packed {
      logic                 kind;
      logic [WORD_BITS-1:0] start_position;
      logic [WORD_BITS-1:0] match_count;
      logic                 last;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type first;
      rsp_word_type second;
   } push_type;

   typedef struct packed {
      logic                 hit;
      logic [WORD_BITS-1:0] start;
   } verdict_type;

   function automatic logic [WORD_BITS-1:0] fold(input logic [WORD_BITS-1:0] c,
                                                 input logic exact);
      logic [WORD_BITS-1:0] r;
      r = c;
      if (!exact && c >= 32'h41 && c <= 32'h5A) begin
         r = c + 32'h20;
      end
      return r;
   endfunction

   function automatic logic is_break(input logic [WORD_BITS-1:0] c);
      logic r;
      r = 1'b0;
      if (c <= 32'h20) begin
         r = 1'b1;
      end else begin
         case (c)
            32'h2E, 32'h2C, 32'h3B, 32'h3A, 32'h22, 32'h27, 32'hB4, 32'h60,
            32'hB0, 32'h5E, 32'h21, 32'h3F, 32'h26, 32'h24, 32'h40, 32'hA7,
            32'h25, 32'h23, 32'h7E, 32'h5B, 32'h5D, 32'h28, 32'h29, 32'h7B,
            32'h7D, 32'h3C, 32'h3E, 32'h2D, 32'h3D, 32'h2B, 32'h2A, 32'h2F,
            32'h5C, 32'h7C: r = 1'b1;
            default: r = 1'b0;
         endcase
      end
      return r;
   endfunction

endpackage

>>> design/wwts_if.sv
// Request and response channel interfaces of the whole-word text search core.
// Depends on wwts_pkg for field widths.

interface wwts_req_if #(
   parameter int CHAR_BITS = wwts_pkg::CHAR_BITS_DEF
);
   logic                              valid;
   logic                              ready;
   logic [wwts_pkg::OPCODE_W-1:0]     opcode;
   logic [wwts_pkg::PIDX_W-1:0]       pattern_index;
   logic [CHAR_BITS-1:0]              char_code;

   modport source (output valid, opcode, pattern_index, char_code, input ready);
   modport sink   (input valid, opcode, pattern_index, char_code, output ready);
endinterface

interface wwts_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              kind;
   logic [wwts_pkg::WORD_BITS-1:0]    start_position;
   logic [wwts_pkg::WORD_BITS-1:0]    match_count;
   logic                              last;

   modport source (output valid, kind, start_position, match_count, last, input ready);
   modport sink   (input valid, kind, start_position, match_count, last, output ready);
endinterface

>>> design/whole_word_text_search_core.sv
// Whole-word text search core: APB registers, item register, window, judge and result queue.
// Depends on wwts_pkg, wwts_if, wwts_judge and wwts_out_fifo.
// A result word passes through the item register and the result queue before it is valid.
// Throughput: one item per cycle while the result queue has room; an end-of-text item with a
// final hit gives two words, drained one per cycle while the receiver is ready.
// Reset (synchronous): registers to defaults, window and counters cleared; pattern unwritten.

module whole_word_text_search_core #(
   parameter int MAX_PATTERN = wwts_pkg::MAX_PATTERN_DEF,
   parameter int CHAR_BITS   = wwts_pkg::CHAR_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   wwts_req_if.sink                        req_ch,
   wwts_rsp_if.source                      rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [wwts_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [wwts_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [wwts_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   localparam int WIN_IDX_W = $clog2(MAX_PATTERN + 1);
   localparam int PAT_IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int WORD_BITS = wwts_pkg::WORD_BITS;

   logic [wwts_pkg::PLEN_W-1:0]   plen_ff;
   logic                          case_ff;
   logic                          whole_ff;
   logic                          csr_write;
   wwts_pkg::reg_index_type       csr_index;

   logic                          stg_valid_ff;
   logic [wwts_pkg::OPCODE_W-1:0] stg_op_ff;
   logic [wwts_pkg::PIDX_W-1:0]   stg_idx_ff;
   logic [CHAR_BITS-1:0]          stg_char_ff;

   logic [CHAR_BITS-1:0]          pattern_ff [MAX_PATTERN];
   logic [CHAR_BITS-1:0]          window_ff  [MAX_PATTERN+1];
   logic [CHAR_BITS-1:0]          window_in  [MAX_PATTERN+1];
   logic [WORD_BITS-1:0]          chars_seen_ff, chars_seen_in;
   logic [WORD_BITS-1:0]          accepted_ff, accepted_in;
   logic [WORD_BITS-1:0]          earliest_ff, earliest_in;

   logic                          req_take;
   logic                          advance;
   logic                          fifo_room;
   logic                          fifo_valid;
   wwts_pkg::rsp_word_type        fifo_word;
   wwts_pkg::push_type            push;
   wwts_pkg::verdict_type         verdict;
   logic [WIN_IDX_W-1:0]          active_len;
   logic [WORD_BITS-1:0]          accepted_inc;
   logic [WORD_BITS:0]            next_start_sum;
   logic [WORD_BITS-1:0]          next_start;

   // configuration port
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = wwts_pkg::reg_index_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff  <= wwts_pkg::PLEN_W'(1);
         case_ff  <= 1'b0;
         whole_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            wwts_pkg::REG_PATTERN_LENGTH: plen_ff  <= csr_pwdata[wwts_pkg::PLEN_W-1:0];
            wwts_pkg::REG_CASE_SENSITIVE: case_ff  <= csr_pwdata[0];
            wwts_pkg::REG_WHOLE_WORD:     whole_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         wwts_pkg::REG_PATTERN_LENGTH: csr_prdata = 32'(plen_ff);
         wwts_pkg::REG_CASE_SENSITIVE: csr_prdata = 32'(case_ff);
         wwts_pkg::REG_WHOLE_WORD:     csr_prdata = 32'(whole_ff);
         default:                      csr_prdata = '0;
      endcase
   end

   // item register
   assign advance      = stg_valid_ff && fifo_room;
   assign req_ch.ready = !stg_valid_ff || fifo_room;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else if (req_take) begin
         stg_valid_ff <= 1'b1;
      end else if (advance) begin
         stg_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stg_op_ff   <= req_ch.opcode;
         stg_idx_ff  <= req_ch.pattern_index;
         stg_char_ff <= CHAR_BITS'(req_ch.char_code);
      end
   end

   // pattern store
   always_ff @(posedge clock) begin
      if (advance && stg_op_ff == wwts_pkg::OP_LOAD && 32'(stg_idx_ff) < MAX_PATTERN) begin
         pattern_ff[PAT_IDX_W'(stg_idx_ff)] <= stg_char_ff;
      end
   end

   // judge
   always_comb begin
      if (plen_ff == '0) begin
         active_len = WIN_IDX_W'(1);
      end else if ({1'b0, plen_ff} > 7'(MAX_PATTERN)) begin
         active_len = WIN_IDX_W'(MAX_PATTERN);
      end else begin
         active_len = WIN_IDX_W'(plen_ff);
      end
   end

   wwts_judge #(
      .MAX_PATTERN (MAX_PATTERN),
      .CHAR_BITS   (CHAR_BITS)
   ) u_judge (
      .pattern        (pattern_ff),
      .window         (window_ff),
      .active_len     (active_len),
      .chars_seen     (chars_seen_ff),
      .earliest       (earliest_ff),
      .case_sensitive (case_ff),
      .whole_word     (whole_ff),
      .at_end         (stg_op_ff == wwts_pkg::OP_END),
      .after_char     (stg_char_ff),
      .verdict        (verdict)
   );

   assign accepted_inc   = (accepted_ff == wwts_pkg::SAT_WORD) ? accepted_ff
                                                               : accepted_ff + 32'd1;
   assign next_start_sum = {1'b0, verdict.start} + 33'(active_len);
   assign next_start     = next_start_sum[WORD_BITS] ? wwts_pkg::SAT_WORD
                                                     : next_start_sum[WORD_BITS-1:0];

   // state update and result words
   always_comb begin
      window_in     = window_ff;
      chars_seen_in = chars_seen_ff;
      accepted_in   = accepted_ff;
      earliest_in   = earliest_ff;
      push          = '0;
      if (advance) begin
         case (wwts_pkg::opcode_type'(stg_op_ff))
            wwts_pkg::OP_TEXT: begin
               window_in[0] = stg_char_ff;
               for (int k = 1; k <= MAX_PATTERN; k++) begin
                  window_in[k] = window_ff[k-1];
               end
               if (chars_seen_ff != wwts_pkg::SAT_WORD) begin
                  chars_seen_in = chars_seen_ff + 32'd1;
               end
               if (verdict.hit) begin
                  accepted_in = accepted_inc;
                  earliest_in = next_start;
                  push.count  = 2'd1;
                  push.first  = '{wwts_pkg::KIND_MATCH, verdict.start, accepted_inc, 1'b1};
               end
            end
            wwts_pkg::OP_END: begin
               for (int k = 0; k <= MAX_PATTERN; k++) begin
                  window_in[k] = '0;
               end
               chars_seen_in = '0;
               accepted_in   = '0;
               earliest_in   = 32'd1;
               if (verdict.hit) begin
                  push.count  = 2'd2;
                  push.first  = '{wwts_pkg::KIND_MATCH, verdict.start, accepted_inc, 1'b0};
                  push.second = '{wwts_pkg::KIND_DONE, '0, accepted_inc, 1'b1};
               end else begin
                  push.count  = 2'd1;
                  push.first  = '{wwts_pkg::KIND_DONE, '0, accepted_ff, 1'b1};
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= MAX_PATTERN; k++) begin
            window_ff[k] <= '0;
         end
         chars_seen_ff <= '0;
         accepted_ff   <= '0;
         earliest_ff   <= 32'd1;
      end else begin
         window_ff     <= window_in;
         chars_seen_ff <= chars_seen_in;
         accepted_ff   <= accepted_in;
         earliest_ff   <= earliest_in;
      end
   end

   // result queue
   wwts_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (fifo_room),
      .out_valid (fifo_valid),
      .out_ready (rsp_ch.ready),
      .out_word  (fifo_word)
   );

   assign rsp_ch.valid          = fifo_valid;
   assign rsp_ch.kind           = fifo_word.kind;
   assign rsp_ch.start_position = fifo_word.start_position;
   assign rsp_ch.match_count    = fifo_word.match_count;
   assign rsp_ch.last           = fifo_word.last;

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && stg_op_ff == wwts_pkg::OP_END) |=>
         (chars_seen_ff == '0 && accepted_ff == '0 && earliest_ff == 32'd1))
      else $error("end of text did not clear the search state");

   a_done_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.kind == wwts_pkg::KIND_DONE) |->
         (rsp_ch.last && rsp_ch.start_position == '0))
      else $error("done word without last or with a start position");

   a_match_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.kind == wwts_pkg::KIND_MATCH) |->
         (rsp_ch.match_count != '0 && rsp_ch.start_position != '0))
      else $error("match word with zero count or zero start");

   a_pair_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (advance && stg_op_ff == wwts_pkg::OP_END))
      else $error("two result words from an item other than end of text");

endmodule

>>> design/wwts_judge.sv
// Candidate judge: parallel window compare, start check and word-boundary test.
// Depends on wwts_pkg (fold, is_break, verdict_type).

module wwts_judge #(
   parameter int MAX_PATTERN = wwts_pkg::MAX_PATTERN_DEF,
   parameter int CHAR_BITS   = wwts_pkg::CHAR_BITS_DEF,
   localparam int WIN_IDX_W  = $clog2(MAX_PATTERN + 1)
) (
   input  logic [CHAR_BITS-1:0]           pattern [MAX_PATTERN],
   input  logic [CHAR_BITS-1:0]           window  [MAX_PATTERN+1],
   input  logic [WIN_IDX_W-1:0]           active_len,
   input  logic [wwts_pkg::WORD_BITS-1:0] chars_seen,
   input  logic [wwts_pkg::WORD_BITS-1:0] earliest,
   input  logic                           case_sensitive,
   input  logic                           whole_word,
   input  logic                           at_end,
   input  logic [CHAR_BITS-1:0]           after_char,
   output wwts_pkg::verdict_type          verdict
);

   logic [MAX_PATTERN-1:0]         lane_bad;
   logic [wwts_pkg::WORD_BITS-1:0] len_word;
   logic [wwts_pkg::WORD_BITS-1:0] start;
   logic                           before_ok;
   logic                           after_ok;

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_lane
      assign lane_bad[i] = (WIN_IDX_W'(i) < active_len) &&
         (wwts_pkg::fold(32'(pattern[i]), case_sensitive) !=
          wwts_pkg::fold(32'(window[active_len - WIN_IDX_W'(i + 1)]), case_sensitive));
   end

   assign len_word  = 32'(active_len);
   assign start     = chars_seen - len_word + 32'd1;
   assign before_ok = (chars_seen == len_word) ||
      wwts_pkg::is_break(wwts_pkg::fold(32'(window[active_len]), case_sensitive));
   assign after_ok  = at_end ||
      wwts_pkg::is_break(wwts_pkg::fold(32'(after_char), case_sensitive));

   assign verdict.start = start;
   assign verdict.hit   = (chars_seen >= len_word) && (start >= earliest) &&
                          (lane_bad == '0) && (!whole_word || (before_ok && after_ok));

endmodule

>>> design/wwts_out_fifo.sv
// Result word queue: takes up to two words a cycle, hands out one word a cycle while out_ready is high.
// Depends on wwts_pkg (rsp_word_type, push_type, FIFO_DEPTH).

module wwts_out_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  wwts_pkg::push_type     push,
   output logic                   room,
   output logic                   out_valid,
   input  logic                   out_ready,
   output wwts_pkg::rsp_word_type out_word
);

   localparam int PTR_W = $clog2(wwts_pkg::FIFO_DEPTH);
   localparam int CNT_W = $clog2(wwts_pkg::FIFO_DEPTH + 1);

   wwts_pkg::rsp_word_type mem [wwts_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0]       wr_ff;
   logic [PTR_W-1:0]       rd_ff;
   logic [CNT_W-1:0]       count_ff;
   logic                   pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign out_word  = mem[rd_ff];
   assign room      = (count_ff <= CNT_W'(wwts_pkg::FIFO_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_ff + PTR_W'(push.count);
         rd_ff    <= rd_ff + PTR_W'(pop);
         count_ff <= count_ff + CNT_W'(push.count) - CNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_ff + PTR_W'(1)] <= push.second;
      end
   end

endmodule

>>> bench/tb_whole_word_text_search_core.sv
// Self-checking bench for whole_word_text_search_core: table-driven directed words, then
// random pattern/text phases; results checked against a typed row or the in-bench predictor.
// Depends on wwts_pkg, wwts_if and the core itself.

module tb_whole_word_text_search_core;

   localparam int          ADDR_W       = wwts_pkg::CSR_ADDR_W;
   localparam int          RANDOM_WORDS = 700;
   localparam int          STALL_LIMIT  = 4000;
   localparam int          LONG_HOLD    = 300;
   localparam logic [1:0]  OP_UNUSED    = 2'd3;

   localparam logic [15:0] BREAK_MARKS [34] = '{
      16'h2E, 16'h2C, 16'h3B, 16'h3A, 16'h22, 16'h27, 16'hB4, 16'h60, 16'hB0, 16'h5E,
      16'h21, 16'h3F, 16'h26, 16'h24, 16'h40, 16'hA7, 16'h25, 16'h23, 16'h7E, 16'h5B,
      16'h5D, 16'h28, 16'h29, 16'h7B, 16'h7D, 16'h3C, 16'h3E, 16'h2D, 16'h3D, 16'h2B,
      16'h2A, 16'h2F, 16'h5C, 16'h7C
   };

   typedef struct packed {
      logic                    is_csr;
      wwts_pkg::reg_index_type sel;
      logic [5:0]              value;
      logic [1:0]              op;
      logic [4:0]              idx;
      logic [15:0]             ch;
      logic                    typed;
      logic                    typed_count;
      wwts_pkg::rsp_word_type  typed_rsp;
   } stim_word_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [ADDR_W-1:0]               csr_paddr;
   logic [wwts_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [wwts_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   wwts_req_if req_ch ();
   wwts_rsp_if rsp_ch ();

   whole_word_text_search_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // search predictor state
   logic [5:0]   plen_reg  = 6'd1;
   logic         exact_reg = 1'b0;
   logic         whole_reg = 1'b0;
   logic [15:0]  pat_mirror [32] = '{default: '0};
   logic [15:0]  window [33] = '{default: '0};
   logic [31:0]  seen     = '0;
   logic [31:0]  accepted = '0;
   logic [31:0]  earliest = 32'd1;

   wwts_pkg::rsp_word_type awaited_words [$];
   stim_word_type          outbound_words [$];
   stim_word_type          cur_item;
   int           words_queued = 0;
   int           words_taken  = 0;
   int           useful_words = 0;
   int           errors       = 0;
   int           quiet_cycles = 0;
   bit           calm         = 1'b0;
   bit           hold_request = 1'b0;
   logic [15:0]  gen_pat [32];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned span_of(input logic [5:0] p);
      if (p == 6'd0) return 1;
      if (p > 6'd32) return 32;
      return 32'(p);
   endfunction

   function automatic logic [15:0] fold_char(input logic [15:0] c);
      if (!exact_reg && c inside {[16'h41:16'h5A]}) return c | 16'h20;
      return c;
   endfunction

   function automatic logic word_break(input logic [15:0] c);
      if (c <= 16'd32) return 1'b1;
      foreach (BREAK_MARKS[i]) begin
         if (BREAK_MARKS[i] == c) return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic judge_window(input logic after_end, input logic [15:0] after_char,
                               output logic [31:0] hit);
      int unsigned len;
      logic [31:0] first;
      logic [32:0] next_first;
      logic        same;
      logic        bounded;
      hit = '0;
      len = span_of(plen_reg);
      if (seen < len) return;
      first = seen - len + 32'd1;
      if (first < earliest) return;
      same = 1'b1;
      for (int i = 0; i < len; i++) begin
         if (fold_char(pat_mirror[i]) != fold_char(window[len-1-i])) same = 1'b0;
      end
      bounded = (seen == len || word_break(fold_char(window[len])))
                && (after_end || word_break(fold_char(after_char)));
      if (!same || (whole_reg && !bounded)) return;
      if (accepted != '1) accepted++;
      next_first = {1'b0, first} + 33'(len);
      earliest = next_first[32] ? '1 : next_first[31:0];
      hit = first;
   endtask

   task automatic apply_search_word(input stim_word_type w);
      wwts_pkg::rsp_word_type produced [$];
      logic [31:0]            hit;
      case (w.op)
         wwts_pkg::OP_LOAD: pat_mirror[w.idx] = w.ch;
         wwts_pkg::OP_TEXT: begin
            judge_window(1'b0, w.ch, hit);
            for (int i = 32; i > 0; i--) window[i] = window[i-1];
            window[0] = w.ch;
            if (seen != '1) seen++;
            if (hit != '0) produced.push_back('{wwts_pkg::KIND_MATCH, hit, accepted, 1'b1});
         end
         wwts_pkg::OP_END: begin
            judge_window(1'b1, 16'd0, hit);
            if (hit != '0) produced.push_back('{wwts_pkg::KIND_MATCH, hit, accepted, 1'b0});
            produced.push_back('{wwts_pkg::KIND_DONE, 32'd0, accepted, 1'b1});
            foreach (window[i]) window[i] = '0;
            seen     = '0;
            accepted = '0;
            earliest = 32'd1;
         end
         default: ;
      endcase
      if (w.typed) begin
         if (w.typed_count) awaited_words.push_back(w.typed_rsp);
      end else begin
         foreach (produced[i]) awaited_words.push_back(produced[i]);
      end
   endtask

   function automatic stim_word_type plain_word(input logic [1:0] op, input logic [4:0] idx,
                                                input logic [15:0] ch);
      stim_word_type w;
      w = '0;
      w.op  = op;
      w.idx = idx;
      w.ch  = ch;
      return w;
   endfunction

   function automatic stim_word_type typed_word(input logic [1:0] op, input logic [4:0] idx,
                                                input logic [15:0] ch, input logic n,
                                                input wwts_pkg::rsp_word_type r);
      stim_word_type w;
      w = plain_word(op, idx, ch);
      w.typed       = 1'b1;
      w.typed_count = n;
      w.typed_rsp   = r;
      return w;
   endfunction

   function automatic stim_word_type csr_row(input wwts_pkg::reg_index_type sel,
                                             input logic [5:0] value);
      stim_word_type w;
      w = '0;
      w.is_csr = 1'b1;
      w.sel    = sel;
      w.value  = value;
      return w;
   endfunction

   function automatic logic [15:0] pick_char();
      int unsigned r;
      r = $urandom_range(0, 15);
      if (r < 5) return 16'h61;
      if (r < 8) return 16'h62;
      if (r < 10) return 16'h41;
      case (r)
         10: return 16'h42;
         11: return 16'h5A;
         12: return 16'h7A;
         13: return 16'h40;
         14: return 16'h5B;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [15:0] pick_break();
      if ($urandom_range(0, 1) == 0) return 16'($urandom_range(0, 32));
      return BREAK_MARKS[$urandom_range(0, 33)];
   endfunction

   task automatic offer(input stim_word_type w);
      outbound_words.push_back(w);
      words_queued++;
      if (w.op != OP_UNUSED) useful_words++;
   endtask

   task automatic offer_copy(input int unsigned span);
      logic [15:0] c;
      for (int i = 0; i < span; i++) begin
         c = gen_pat[i];
         if ((c | 16'h20) inside {[16'h61:16'h7A]} && $urandom_range(0, 3) == 0) c = c ^ 16'h20;
         offer(plain_word(wwts_pkg::OP_TEXT, 5'd0, c));
      end
   endtask

   task automatic settle();
      while (words_taken != words_queued || awaited_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input wwts_pkg::reg_index_type sel, input logic [5:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'(4 * int'(sel));
      csr_pwdata  <= wwts_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (sel)
         wwts_pkg::REG_PATTERN_LENGTH: plen_reg  = value;
         wwts_pkg::REG_CASE_SENSITIVE: exact_reg = value[0];
         wwts_pkg::REG_WHOLE_WORD:     whole_reg = value[0];
         default: ;
      endcase
   endtask

   initial begin : sender
      int            gap;
      stim_word_type w;
      gap = 0;
      req_ch.valid         <= 1'b0;
      req_ch.opcode        <= '0;
      req_ch.pattern_index <= '0;
      req_ch.char_code     <= '0;
      cur_item             <= '0;
      forever begin
         @(posedge clock);
         if (!reset && (!req_ch.valid || req_ch.ready)) begin
            if (gap > 0) begin
               gap--;
               req_ch.valid <= 1'b0;
            end else if (outbound_words.size() > 0) begin
               w = outbound_words.pop_front();
               req_ch.valid         <= 1'b1;
               req_ch.opcode        <= w.op;
               req_ch.pattern_index <= w.idx;
               req_ch.char_code     <= w.ch;
               cur_item             <= w;
               if (!calm && $urandom_range(0, 11) == 0) gap = $urandom_range(1, 17);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   initial begin : receiver
      int hold;
      hold = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold = LONG_HOLD;
         end
         if (hold > 0) begin
            hold--;
            rsp_ch.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            hold = $urandom_range(0, 16);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         apply_search_word(cur_item);
         words_taken++;
      end
   end

   always @(posedge clock) begin : check_words
      wwts_pkg::rsp_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_words.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result word: kind %0d start %0d count %0d last %0d",
                        rsp_ch.kind, rsp_ch.start_position, rsp_ch.match_count, rsp_ch.last);
         end else begin
            want = awaited_words.pop_front();
            if (want.kind !== rsp_ch.kind || want.start_position !== rsp_ch.start_position
                || want.match_count !== rsp_ch.match_count || want.last !== rsp_ch.last) begin
               errors++;
               if (errors <= 10)
                  $display({"result mismatch: expected kind %0d start %0d count %0d last %0d,",
                            " got kind %0d start %0d count %0d last %0d"},
                           want.kind, want.start_position, want.match_count, want.last,
                           rsp_ch.kind, rsp_ch.start_position, rsp_ch.match_count, rsp_ch.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= STALL_LIMIT);
      $display("tb_whole_word_text_search_core: errors");
      $finish;
   end

   initial begin : stimulus
      stim_word_type script [27];
      int            phase;
      int unsigned   span;
      int unsigned   pick;
      int unsigned   tokens;
      int unsigned   slot;
      logic [5:0]    plen;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      reset       <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      script = '{
         typed_word(wwts_pkg::OP_END, 5'd0, 16'h0000, 1'b1,
                    '{wwts_pkg::KIND_DONE, 32'd0, 32'd0, 1'b1}),
         typed_word(OP_UNUSED, 5'd31, 16'hFFFF, 1'b0, '0),
         typed_word(wwts_pkg::OP_LOAD, 5'd0, 16'h61, 1'b0, '0),
         plain_word(wwts_pkg::OP_TEXT, 5'd0, 16'h41),
         plain_word(wwts_pkg::OP_TEXT, 5'd0, 16'h61),
         plain_word(wwts_pkg::OP_TEXT, 5'd0, 16'hFFFF),
         plain_word(wwts_pkg::OP_TEXT, 5'd0, 16'h0000),
         plain_word(wwts_pkg::OP_END, 5'd0, 16'h0000),
         csr_row(wwts_pkg::REG_PATTERN_LENGTH, 6'd3),
         csr_row(wwts_pkg::REG_CASE_SENSITIVE, 6'd1),
         csr_row(wwts_pkg::REG_WHOLE_WORD, 6'd1),
         typed_word(wwts_pkg::OP_LOAD, 5'd0, 16'h63, 1'b0, '0),
         typed_word(wwts_pkg::OP_LOAD, 5'd1, 16'h61, 1'b0, '0),
         typed_word(wwts_pkg::OP_LOAD, 5'd2, 16'h74, 1'b0, '0),
         plain_word(wwts_pkg::OP_TEXT, 5'd0, 16'h63),
         plain_word(wwts_pkg::OP_TEXT, 5'd0, 16'h61),
         plain_word(wwts_pkg::OP_TEXT, 5'd0, 16'h74),
         plain_word(wwts_pkg::OP_TEXT, 5'd0, 16'h2E),
         plain_word(wwts_pkg::OP_TEXT, 5'd0, 16'h43),
         plain_word(wwts_pkg::OP_TEXT, 5'd0, 16'h61),
         plain_word(wwts_pkg::OP_TEXT, 5'd0, 16'h74),
         plain_word(wwts_pkg::OP_TEXT, 5'd0, 16'h73),
         plain_word(wwts_pkg::OP_TEXT, 5'd0, 16'h20),
         plain_word(wwts_pkg::OP_TEXT, 5'd0, 16'h63),
         plain_word(wwts_pkg::OP_TEXT, 5'd0, 16'h61),
         plain_word(wwts_pkg::OP_TEXT, 5'd0, 16'h74),
         plain_word(wwts_pkg::OP_END, 5'd0, 16'h0000)
      };

      foreach (script[i]) begin
         if (script[i].is_csr) begin
            settle();
            csr_write(script[i].sel, script[i].value);
         end else begin
            offer(script[i]);
         end
      end

      useful_words = 0;
      phase = 0;
      while (useful_words < RANDOM_WORDS) begin
         settle();
         if (useful_words > RANDOM_WORDS - 100) calm = 1'b1;
         case (phase)
            1: plen = 6'd32;
            2: plen = 6'd63;
            3: plen = 6'd0;
            4: plen = 6'd2;
            default: begin
               pick = $urandom_range(0, 19);
               if (pick == 0) plen = 6'd32;
               else if (pick == 1) plen = 6'($urandom_range(33, 63));
               else if (pick < 8) plen = 6'd1;
               else plen = 6'($urandom_range(2, 5));
            end
         endcase
         csr_write(wwts_pkg::REG_PATTERN_LENGTH, plen);
         csr_write(wwts_pkg::REG_CASE_SENSITIVE, 6'($urandom_range(0, 1)));
         csr_write(wwts_pkg::REG_WHOLE_WORD, 6'($urandom_range(0, 3) != 0));
         span = span_of(plen);
         for (int i = 0; i < span; i++) begin
            gen_pat[i] = pick_char();
            offer(plain_word(wwts_pkg::OP_LOAD, 5'(i), gen_pat[i]));
         end
         if (phase == 4) begin
            hold_request = 1'b1;
            repeat (30) begin
               offer_copy(span);
               offer(plain_word(wwts_pkg::OP_END, 5'd0, 16'h0000));
            end
         end else begin
            tokens = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 14);
            repeat (tokens) begin
               pick = $urandom_range(0, 99);
               if (pick < 35) begin
                  offer_copy(span);
               end else if (pick < 60) begin
                  offer(plain_word(wwts_pkg::OP_TEXT, 5'd0, pick_break()));
               end else if (pick < 85) begin
                  offer(plain_word(wwts_pkg::OP_TEXT, 5'd0, pick_char()));
               end else if (pick < 91) begin
                  offer(plain_word(wwts_pkg::OP_TEXT, 5'd0, 16'($urandom_range(0, 65535))));
               end else if (pick < 95) begin
                  offer(plain_word(OP_UNUSED, 5'($urandom_range(0, 31)),
                                   16'($urandom_range(0, 65535))));
               end else begin
                  slot = $urandom_range(0, 31);
                  gen_pat[slot] = pick_char();
                  offer(plain_word(wwts_pkg::OP_LOAD, 5'(slot), gen_pat[slot]));
               end
            end
            if ($urandom_range(0, 9) != 0) offer(plain_word(wwts_pkg::OP_END, 5'd0, 16'h0000));
         end
         phase++;
      end

      settle();
      if (errors == 0 && awaited_words.size() == 0) begin
         $display("tb_whole_word_text_search_core: clean");
      end else begin
         $display("tb_whole_word_text_search_core: errors");
      end
      $finish;
   end

endmodule

>>> whole_word_text_search_core.f
design/wwts_pkg.sv
design/wwts_if.sv
design/wwts_judge.sv
design/wwts_out_fifo.sv
design/whole_word_text_search_core.sv
bench/tb_whole_word_text_search_core.sv
